FILE: sv/process_queue_priority_pop_defines.svh
// Assertion macros for the process queue datapath RTL.
`ifndef PROCESS_QUEUE_PRIORITY_POP_DEFINES_SVH
`define PROCESS_QUEUE_PRIORITY_POP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PQP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PQP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pqp_pkg.sv
// Types and constants shared by the process queue modules.
`default_nettype none

package pqp_pkg;

  localparam int unsigned ModeW     = 2;
  localparam int unsigned IdW       = 16;
  localparam int unsigned RunTimeW  = 32;
  localparam int unsigned PrioW     = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned HeldW     = 5;
  localparam int unsigned RecW      = IdW + RunTimeW + PrioW;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 72;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH       = 2'd0,
    MODE_POP        = 2'd1,
    MODE_REMOVE_MAX = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_in;     // capture the request
    logic do_push;     // write the record at the tail, count up
    logic set_full;    // report full
    logic set_empty;   // report empty
    logic scan_init;   // start the priority scan
    logic scan_step;   // one scan read / compare
    logic head_pop;    // winner is at the head: advance head
    logic shift_init;  // start closing the gap behind the winner
    logic shift_step;  // one move toward the head
    logic shift_done;  // count down after the shift
    logic resp_load;   // load the output register
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  empty;
    logic  scan_done;
    logic  best_at_head;
    logic  shift_done;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/pqp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pqp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/pqp_ctrl.sv
// Sequencer of the process queue: decodes a request and steps the datapath.
`default_nettype none

module pqp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire pqp_pkg::sts_t sts_i,
  output pqp_pkg::cmd_t      cmd_o
);

  pqp_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pqp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pqp_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = pqp_pkg::S_DECODE;
        end
      end
      pqp_pkg::S_DECODE: begin
        priority if ((sts_i.mode == pqp_pkg::MODE_POP ||
                      sts_i.mode == pqp_pkg::MODE_REMOVE_MAX) && !sts_i.empty) begin
          state_d = pqp_pkg::S_SCAN;
        end else begin
          state_d = pqp_pkg::S_RESP;
        end
      end
      pqp_pkg::S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.best_at_head ? pqp_pkg::S_RESP : pqp_pkg::S_SHIFT;
        end
      end
      pqp_pkg::S_SHIFT: begin
        if (sts_i.shift_done) begin
          state_d = pqp_pkg::S_RESP;
        end
      end
      pqp_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          state_d = pqp_pkg::S_IDLE;
        end
      end
      default: state_d = pqp_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      pqp_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.load_in   = s_axis_tvalid_i;
      end
      pqp_pkg::S_DECODE: begin
        unique case (sts_i.mode)
          pqp_pkg::MODE_PUSH: begin
            cmd_o.set_full = sts_i.full;
            cmd_o.do_push  = !sts_i.full;
          end
          pqp_pkg::MODE_POP, pqp_pkg::MODE_REMOVE_MAX: begin
            cmd_o.set_empty = sts_i.empty;
            cmd_o.scan_init = !sts_i.empty;
          end
          default: ;
        endcase
      end
      pqp_pkg::S_SCAN: begin
        cmd_o.scan_step  = 1'b1;
        cmd_o.head_pop   = sts_i.scan_done && sts_i.best_at_head;
        cmd_o.shift_init = sts_i.scan_done && !sts_i.best_at_head;
      end
      pqp_pkg::S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        cmd_o.shift_done = sts_i.shift_done;
      end
      pqp_pkg::S_RESP: begin
        cmd_o.resp_load = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/pqp_dpath.sv
// Datapath of the process queue: record store, scan, shift and output register.
`default_nettype none
`include "process_queue_priority_pop_defines.svh"

module pqp_dpath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire pqp_pkg::cmd_t                  cmd_i,
  output pqp_pkg::sts_t                       sts_o,
  input  wire logic [pqp_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  wire logic [pqp_pkg::ModeW-1:0]      s_axis_tuser_i,
  input  wire logic                           m_axis_tready_i,
  output logic                                m_axis_tvalid_o,
  output logic      [pqp_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic      [pqp_pkg::StatusW-1:0]    m_axis_tuser_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] DepthS = SW'(QUEUE_DEPTH);
  localparam int unsigned RW = pqp_pkg::RecW;
  localparam int unsigned PW = pqp_pkg::PrioW;

  // Control state
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          rd_valid_q, rd_valid_d;
  logic          m_valid_q, m_valid_d;

  // Working registers
  pqp_pkg::mode_e   mode_q;
  logic [RW-1:0]    in_rec_q;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    len_q, len_d;
  logic [CW-1:0]    rd_pos_q;
  logic [CW-1:0]    best_pos_q, best_pos_d;
  logic [RW-1:0]    best_rec_q, best_rec_d;
  pqp_pkg::status_e status_q, status_d;
  logic             got_q, got_d;
  logic [RW-1:0]                 out_rec_q;
  pqp_pkg::status_e              out_status_q;
  logic [pqp_pkg::HeldW-1:0]     out_held_q;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  logic rd_issue;
  logic shift_wr;
  logic take_best;

  // Map a position counted from the head to a RAM address.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(pos);
    if (sum >= DepthS) begin
      sum = sum - DepthS;
    end
    return sum[AW-1:0];
  endfunction

  pqp_ram #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read one entry per cycle during scan and shift
  always_comb begin
    rd_issue  = (cmd_i.scan_step && (idx_q < len_q)) ||
                (cmd_i.shift_step && (idx_q < count_q));
    ram_raddr = phys(head_q, idx_q);
  end

  // Write the tail on push, or close the gap one place behind the read
  always_comb begin
    shift_wr  = cmd_i.shift_step && rd_valid_q;
    ram_we    = cmd_i.do_push || shift_wr;
    ram_waddr = cmd_i.do_push ? phys(head_q, count_q) : phys(head_q, rd_pos_q - 1'b1);
    ram_wdata = cmd_i.do_push ? in_rec_q : ram_rdata;
  end

  // Keep the first entry seen with the largest priority
  always_comb begin
    take_best = cmd_i.scan_step && rd_valid_q &&
                ((rd_pos_q == '0) ||
                 ($signed(ram_rdata[PW-1:0]) > $signed(best_rec_q[PW-1:0])));
  end

  // Next values of queue and sequencing registers
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    idx_d      = idx_q;
    len_d      = len_q;
    best_pos_d = take_best ? rd_pos_q : best_pos_q;
    best_rec_d = take_best ? ram_rdata : best_rec_q;
    status_d   = status_q;
    got_d      = got_q;
    rd_valid_d = rd_issue;
    m_valid_d  = m_valid_q && !m_axis_tready_i;

    if (cmd_i.load_in) begin
      status_d = pqp_pkg::ST_OK;
      got_d    = 1'b0;
    end
    if (cmd_i.set_full) begin
      status_d = pqp_pkg::ST_FULL;
    end
    if (cmd_i.set_empty) begin
      status_d = pqp_pkg::ST_EMPTY;
    end
    if (cmd_i.do_push) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.scan_init) begin
      idx_d = '0;
      len_d = (mode_q == pqp_pkg::MODE_POP) ? CW'(1) : count_q;
    end
    if (rd_issue) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.head_pop) begin
      head_d  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
      got_d   = 1'b1;
    end
    if (cmd_i.shift_init) begin
      idx_d = best_pos_q + 1'b1;
      got_d = 1'b1;
    end
    if (cmd_i.shift_done) begin
      count_d = count_q - 1'b1;
    end
    if (cmd_i.resp_load) begin
      m_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      rd_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      head_q     <= head_d;
      count_q    <= count_d;
      rd_valid_q <= rd_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q   <= pqp_pkg::mode_e'(s_axis_tuser_i);
      in_rec_q <= {s_axis_tdata_i[15:0], s_axis_tdata_i[47:16], s_axis_tdata_i[63:48]};
    end
    idx_q      <= idx_d;
    len_q      <= len_d;
    rd_pos_q   <= idx_q;
    best_pos_q <= best_pos_d;
    best_rec_q <= best_rec_d;
    status_q   <= status_d;
    got_q      <= got_d;
    if (cmd_i.resp_load) begin
      out_rec_q    <= got_q ? best_rec_q : '0;
      out_status_q <= status_q;
      out_held_q   <= pqp_pkg::HeldW'(count_q);
    end
  end

  // Status to the sequencer
  always_comb begin
    sts_o.mode         = mode_q;
    sts_o.full         = (count_q == DepthC);
    sts_o.empty        = (count_q == '0);
    sts_o.scan_done    = (idx_q == len_q) && !rd_valid_q;
    sts_o.best_at_head = (best_pos_q == '0);
    sts_o.shift_done   = (idx_q == count_q) && !rd_valid_q;
    sts_o.out_free     = !m_valid_q || m_axis_tready_i;
  end

  // Output stream: id, run time, priority, held count from bit 0 up
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_held_q, out_rec_q[PW-1:0],
                            out_rec_q[RW-pqp_pkg::IdW-1:PW],
                            out_rec_q[RW-1:RW-pqp_pkg::IdW]};
  assign m_axis_tuser_o  = out_status_q;

  `PQP_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= DepthC, "record count above depth")
  `PQP_ASSERT_IMPL(a_push_room, cmd_i.do_push, count_q < DepthC, "push into full queue")
  `PQP_ASSERT_NEXT(a_push_count, cmd_i.do_push, count_q == $past(count_q) + 1'b1,
                   "push did not count up")
  `PQP_ASSERT_IMPL(a_shift_target, shift_wr, rd_pos_q != '0, "shift wrote before head")
  `PQP_ASSERT_IMPL(a_pop_nonempty, cmd_i.head_pop || cmd_i.shift_done, count_q != '0,
                   "removal from empty queue")

endmodule

`default_nettype wire

FILE: sv/process_queue_priority_pop.sv
// Top level of the bounded process queue with head pop and max-priority removal.
//
// The queue holds up to QUEUE_DEPTH process records (id, runtime, signed
// priority) in arrival order in a RAM used as a ring. Each input transfer is
// a push to the tail, a pop from the head or removal of the record with the
// largest priority (the one nearest the head on a tie); an unused mode code
// leaves the queue as it is. Each input transfer yields exactly one output
// transfer with a status (full or empty when rejected), the removed record
// (zeros otherwise) and the count held afterwards. Requests are handled one
// at a time. The RAM moves one entry per cycle, and that sets the time. While
// an earlier result still waits in the output register, the next load waits
// too, and a new request is taken only after that load.
`default_nettype none

module process_queue_priority_pop #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // proc_id[15:0], run_time[47:16], priority_req[63:48]
  input  wire logic [pqp_pkg::InDataW-1:0]   s_axis_tdata_i,
  // mode[1:0]
  input  wire logic [pqp_pkg::ModeW-1:0]     s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // out_id[15:0], out_run_time[47:16], out_priority[63:48], held_count[68:64]
  output logic      [pqp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // status[1:0]
  output logic      [pqp_pkg::StatusW-1:0]   m_axis_tuser_o
);

  pqp_pkg::cmd_t cmd;
  pqp_pkg::sts_t sts;

  pqp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  pqp_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

FILE: test/pqp_check_pkg.sv
`timescale 1ns / 100ps
// Record types and the queue result tracker for the process queue testbench.
package pqp_check_pkg;
  import pqp_pkg::*;

  // Request code the block ignores
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [IdW-1:0]             id;
    logic [RunTimeW-1:0]        run_time;
    logic signed [PrioW-1:0]    prio;
  } proc_rec_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    proc_rec_t        rec;
  } request_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    proc_rec_t          rec;
    logic [HeldW-1:0]   held;
  } outcome_t;

  class queue_tracker;
    int unsigned depth;
    proc_rec_t   held_recs[$];   // predicted queue contents, head first
    outcome_t    outcome_q[$];   // predicted results not yet seen
    int unsigned n_mismatch;
    int unsigned n_checked;
    int unsigned n_push, n_full, n_pop, n_remove, n_tie, n_empty, n_unused, peak;

    function new(int unsigned queue_depth);
      depth = queue_depth;
    endfunction

    // Apply one accepted request to the predicted queue and queue its outcome.
    function void note_request(request_t rq);
      outcome_t    o;
      int unsigned best;
      int unsigned i;
      o = '0;
      o.status = ST_OK;
      case (rq.mode)
        MODE_PUSH: begin
          n_push++;
          if (held_recs.size() >= depth) begin
            o.status = ST_FULL;
            n_full++;
          end else begin
            held_recs.push_back(rq.rec);
          end
        end
        MODE_POP, MODE_REMOVE_MAX: begin
          if (rq.mode == MODE_POP) n_pop++;
          else n_remove++;
          if (held_recs.size() == 0) begin
            o.status = ST_EMPTY;
            n_empty++;
          end else begin
            best = 0;
            if (rq.mode == MODE_REMOVE_MAX) begin
              // Strictly greater only, so the entry nearest the head wins a tie
              for (i = 1; i < held_recs.size(); i++)
                if ($signed(held_recs[i].prio) > $signed(held_recs[best].prio)) best = i;
              for (i = 0; i < held_recs.size(); i++)
                if (i != best && held_recs[i].prio == held_recs[best].prio) begin
                  n_tie++;
                  break;
                end
            end
            o.rec = held_recs[best];
            held_recs.delete(best);
          end
        end
        default: n_unused++;
      endcase
      if (held_recs.size() > peak) peak = held_recs.size();
      o.held = HeldW'(held_recs.size());
      outcome_q.push_back(o);
    endfunction

    function void flag(string what);
      n_mismatch++;
      if (n_mismatch <= MaxReports) $display("%s", what);
    endfunction

    // Compare one accepted result with the oldest predicted outcome.
    function void check_result(logic [StatusW-1:0] status, logic [OutDataW-1:0] data);
      outcome_t         exp;
      proc_rec_t        got;
      logic [HeldW-1:0] held;
      got.id       = data[IdW-1:0];
      got.run_time = data[IdW +: RunTimeW];
      got.prio     = data[IdW+RunTimeW +: PrioW];
      held         = data[RecW +: HeldW];
      if (outcome_q.size() == 0) begin
        flag($sformatf("unexpected result: status %0d data %h", status, data));
        return;
      end
      exp = outcome_q.pop_front();
      n_checked++;
      if (status !== exp.status || got.id !== exp.rec.id ||
          got.run_time !== exp.rec.run_time || got.prio !== exp.rec.prio ||
          held !== exp.held)
        flag($sformatf({"result %0d mismatch: expected status %0d id %h run_time %h ",
                        "prio %0d held %0d, got status %0d id %h run_time %h prio %0d held %0d"},
                       n_checked, exp.status, exp.rec.id, exp.rec.run_time,
                       $signed(exp.rec.prio), exp.held, status, got.id, got.run_time,
                       $signed(got.prio), held));
    endfunction

    function bit clean();
      return n_mismatch == 0 && outcome_q.size() == 0;
    endfunction
  endclass

endpackage

FILE: test/tb_process_queue_priority_pop.sv
`timescale 1ns / 100ps
// Top of the process queue testbench: clock, reset, stimulus and result checks.
module tb_process_queue_priority_pop;
  import pqp_pkg::*;
  import pqp_check_pkg::*;

  localparam int unsigned QueueDepth     = 16;
  localparam int unsigned RandomItems    = 900;
  localparam int unsigned HoldAtItem     = 300;
  localparam int unsigned DrainAtItem    = 600;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned SettleCycles   = 60;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [InDataW-1:0]   s_axis_tdata_i;
  logic [ModeW-1:0]     s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OutDataW-1:0]  m_axis_tdata_o;
  logic [StatusW-1:0]   m_axis_tuser_o;

  queue_tracker tracker;
  bit           long_hold_req;
  int unsigned  long_holds;

  process_queue_priority_pop #(
    .QUEUE_DEPTH(QueueDepth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("process_queue_priority_pop regression: fail");
    $finish;
  end

  // Offer one request and hold it until the block takes it
  task automatic send_request(input logic [ModeW-1:0] mode, input proc_rec_t rec);
    request_t rq;
    rq.mode = mode;
    rq.rec  = rec;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= {rec.prio, rec.run_time, rec.id};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_request(rq);
  endtask

  // Idle the input for a number of cycles (at least one)
  task automatic pause_sender(input int unsigned cycles);
    s_axis_tvalid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Idle the input until every predicted result has arrived
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.outcome_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic proc_rec_t make_rec(logic [IdW-1:0] id, logic [RunTimeW-1:0] rt,
                                         logic [PrioW-1:0] prio);
    proc_rec_t r;
    r.id       = id;
    r.run_time = rt;
    r.prio     = prio;
    return r;
  endfunction

  // Random record; priorities cluster near zero so ties are common
  function automatic proc_rec_t rand_rec();
    proc_rec_t r;
    r.id = IdW'($urandom);
    case ($urandom_range(0, 9))
      0:       r.run_time = '0;
      1:       r.run_time = '1;
      default: r.run_time = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.prio = PrioW'(int'($urandom_range(0, 4)) - 2);
      4:          r.prio = 16'sh8000;
      5:          r.prio = 16'sh7fff;
      default:    r.prio = PrioW'($urandom);
    endcase
    return r;
  endfunction

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      tracker.check_result(m_axis_tuser_o, m_axis_tdata_o);
  end

  // Output side: stretches of steady, sparse or bursty stalls, plus one long hold
  initial begin
    int unsigned stretch_left = 0;
    int unsigned hold_left = 0;
    int unsigned kind = 0;
    m_axis_tready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHoldCycles - 1;
        long_holds++;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          kind = $urandom_range(0, 3);
          stretch_left = $urandom_range(8, 60);
        end
        stretch_left--;
        case (kind)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= $urandom_range(0, 1) == 0;
          2:       m_axis_tready_i <= $urandom_range(0, 3) == 0;
          default: m_axis_tready_i <= $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  // Input side: directed requests, then random segments of varying fill pressure
  initial begin
    int unsigned      counted;
    int unsigned      seg_left;
    int unsigned      push_pct;
    int unsigned      burst_left;
    int unsigned      i;
    bit               hold_asked;
    bit               drain_done;
    logic [ModeW-1:0] mode;
    proc_rec_t        rec;

    counted    = 0;
    seg_left   = 0;
    push_pct   = 50;
    burst_left = 0;
    hold_asked = 1'b0;
    drain_done = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    long_hold_req   = 1'b0;
    long_holds      = 0;
    tracker = new(QueueDepth);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Removals and the ignored code on an empty queue
    send_request(MODE_POP, '0);
    send_request(MODE_REMOVE_MAX, '0);
    send_request(MODE_UNUSED, make_rec('1, '1, '1));

    // Fill to the top with field extremes and a tied maximum away from the head
    for (i = 0; i < QueueDepth; i++) begin
      case (i)
        0:       rec = make_rec('0, '0, 16'sh8000);
        1:       rec = make_rec('1, '1, 16'sh7fff);
        5:       rec = make_rec(IdW'($urandom), $urandom, 16'sh7fff);
        9:       rec = make_rec(IdW'($urandom), $urandom, '0);
        default: rec = make_rec(IdW'($urandom), $urandom, PrioW'(int'($urandom_range(0, 4)) - 2));
      endcase
      send_request(MODE_PUSH, rec);
    end

    // Push onto a full queue, ignored code while full, then removals
    send_request(MODE_PUSH, rand_rec());
    send_request(MODE_UNUSED, rand_rec());
    send_request(MODE_REMOVE_MAX, rand_rec());
    send_request(MODE_REMOVE_MAX, rand_rec());
    send_request(MODE_REMOVE_MAX, rand_rec());
    send_request(MODE_POP, rand_rec());

    while (counted < RandomItems) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      seg_left--;
      if ($urandom_range(0, 29) == 0) begin
        mode = MODE_UNUSED;
      end else if ($urandom_range(0, 99) < push_pct) begin
        mode = MODE_PUSH;
      end else begin
        mode = $urandom_range(0, 1) ? MODE_POP : MODE_REMOVE_MAX;
      end
      send_request(mode, rand_rec());
      if (mode != MODE_UNUSED) counted++;

      // Long output hold while the input keeps offering
      if (counted >= HoldAtItem && !hold_asked) begin
        long_hold_req = 1'b1;
        hold_asked = 1'b1;
      end

      if (counted >= DrainAtItem && !drain_done) begin
        wait_drained();
        drain_done = 1'b1;
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      end else begin
        burst_left--;
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Checked %0d results: %0d pushes (%0d refused as full), %0d pops, %0d max removals (%0d with tied priorities)",
             tracker.n_checked, tracker.n_push, tracker.n_full, tracker.n_pop,
             tracker.n_remove, tracker.n_tie);
    $display("%0d removals on an empty queue, %0d ignored codes, peak fill %0d of %0d, %0d long output holds, %0d mismatches",
             tracker.n_empty, tracker.n_unused, tracker.peak, QueueDepth, long_holds,
             tracker.n_mismatch);
    if (tracker.outcome_q.size() != 0)
      $display("%0d predicted results never arrived", tracker.outcome_q.size());
    if (tracker.clean()) begin
      $display("process_queue_priority_pop regression: pass");
    end else begin
      $display("process_queue_priority_pop regression: fail");
    end
    $finish;
  end

endmodule
